// ----- hw/rtl/dcfd_pkg.sv -----
// Shared types and constants for the display command frame decoder.
`timescale 1ns / 1ps

package dcfd_pkg;

  localparam logic [7:0] CMD_RECT = 8'hFE;
  localparam logic [7:0] CMD_CHAR = 8'hFD;
  localparam logic [7:0] CMD_WAVE = 8'hFC;
  localparam logic [7:0] CMD_FONT = 8'hFF;

  localparam int HDR_DEPTH = 12;
  localparam logic [8:0] COUNT_MAX = 9'd511;
  localparam logic [15:0] SIZE_DEFAULT = 16'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    KIND_IGNORED  = 3'd0,
    KIND_RECT     = 3'd1,
    KIND_CHAR     = 3'd2,
    KIND_SAMPLE   = 3'd3,
    KIND_WAVE_END = 3'd4,
    KIND_FONT     = 3'd5,
    KIND_REJECT   = 3'd6
  } kind_t;

  typedef logic [HDR_DEPTH-1:0][7:0] hdr_t;

  typedef struct packed {
    logic       has_sample;
    logic       has_close;
    kind_t      close_kind;
    logic       rect_color_upd;
    logic       rect_has_size;
    logic [7:0] sample_value;
    logic [8:0] sample_index;
    logic [8:0] wave_total;
    hdr_t       hdr;
  } op_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [23:0] fore_color;
    logic [23:0] back_color;
    logic [7:0]  code_byte;
    logic [8:0]  sample_count;
    logic        run_last;
  } res_t;

endpackage

// ----- hw/rtl/dcfd_front.sv -----
// Front end: counts frame bytes, keeps the header bytes and classifies each byte.
`timescale 1ns / 1ps

module dcfd_front #(
  parameter int MAX_SAMPLES = 480
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     frame_byte,
  input  logic           frame_end,
  output logic           op_push,
  output dcfd_pkg::op_t  op
);
  import dcfd_pkg::*;

  logic [8:0] byte_count_r, byte_count_nxt;
  hdr_t       header_r;
  hdr_t       hdr;
  logic [7:0] cmd;
  logic [8:0] idx;
  logic       sample_ok;

  assign idx = byte_count_r;

  always_comb begin
    for (int i = 0; i < HDR_DEPTH; i++) begin
      hdr[i] = (idx == 9'(i)) ? frame_byte : header_r[i];
    end
  end

  assign cmd = hdr[0];

  assign sample_ok = (cmd == CMD_WAVE) && (idx >= 9'd4) &&
                     ({1'b0, idx} < 10'(MAX_SAMPLES + 4));

  always_comb begin
    op = '0;
    op.hdr = hdr;
    op.has_sample = sample_ok;
    op.has_close = frame_end;
    op.sample_value = frame_byte;
    op.sample_index = idx - 9'd4;
    op.wave_total = idx - 9'd3;
    op.close_kind = KIND_IGNORED;
    case (cmd)
      CMD_RECT: begin
        if (idx inside {9'd4, 9'd7, 9'd8, 9'd11}) begin
          op.close_kind = KIND_RECT;
          op.rect_color_upd = (idx == 9'd7) || (idx == 9'd11);
          op.rect_has_size = (idx == 9'd8) || (idx == 9'd11);
        end else begin
          op.close_kind = KIND_REJECT;
        end
      end
      CMD_CHAR: begin
        op.close_kind = (idx == 9'd11) ? KIND_CHAR : KIND_REJECT;
      end
      CMD_WAVE: begin
        if ((idx >= 9'd3) && ({1'b0, idx} <= 10'(MAX_SAMPLES + 3))) begin
          op.close_kind = KIND_WAVE_END;
        end else begin
          op.close_kind = KIND_REJECT;
        end
      end
      CMD_FONT: begin
        op.close_kind = (idx == 9'd5) ? KIND_FONT : KIND_IGNORED;
      end
      default: begin
        op.close_kind = KIND_IGNORED;
      end
    endcase
  end

  assign op_push = accept && (sample_ok || frame_end);

  always_comb begin
    if (frame_end) begin
      byte_count_nxt = '0;
    end else if (byte_count_r < COUNT_MAX) begin
      byte_count_nxt = byte_count_r + 9'd1;
    end else begin
      byte_count_nxt = byte_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
    end else if (accept) begin
      byte_count_r <= byte_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (idx < 9'(HDR_DEPTH))) begin
      header_r[idx[3:0]] <= frame_byte;
    end
  end

endmodule

// ----- hw/rtl/dcfd_queue.sv -----
// Short queue of classified operations between the front and back ends.
`timescale 1ns / 1ps

module dcfd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dcfd_pkg::op_t  push_op,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output dcfd_pkg::op_t  head_op
);
  import dcfd_pkg::*;

  op_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ----- hw/rtl/dcfd_back.sv -----
// Back end: turns queued operations into result items and keeps the rectangle color.
`timescale 1ns / 1ps

module dcfd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  dcfd_pkg::op_t  head_op,
  output logic           head_pop,
  output logic           res_valid,
  output dcfd_pkg::res_t res,
  input  logic           res_pop
);
  import dcfd_pkg::*;

  logic        out_valid_r;
  res_t        res_r, res_nxt;
  logic [23:0] rect_color_r, rect_color_nxt;
  logic        phase_r;
  logic        load;
  logic        emit_sample;
  logic        last_of_op;
  hdr_t        h;

  assign h = head_op.hdr;
  assign load = head_valid && (!out_valid_r || res_pop);
  assign emit_sample = head_op.has_sample && !phase_r;
  assign last_of_op = !(emit_sample && head_op.has_close);
  assign head_pop = load && last_of_op;

  always_comb begin
    res_nxt = '0;
    rect_color_nxt = rect_color_r;
    if (emit_sample) begin
      res_nxt.result_kind = KIND_SAMPLE;
      res_nxt.fore_color = {h[1], h[2], h[3]};
      res_nxt.code_byte = head_op.sample_value;
      res_nxt.sample_count = head_op.sample_index;
      res_nxt.run_last = !head_op.has_close;
    end else begin
      res_nxt.result_kind = head_op.close_kind;
      res_nxt.run_last = 1'b1;
      case (head_op.close_kind)
        KIND_RECT: begin
          if (head_op.rect_color_upd) begin
            rect_color_nxt = head_op.rect_has_size ? {h[9], h[10], h[11]}
                                                   : {h[5], h[6], h[7]};
          end
          res_nxt.pos_x = {h[2], h[1]};
          res_nxt.pos_y = {h[4], h[3]};
          res_nxt.rect_width = head_op.rect_has_size ? {h[6], h[5]} : SIZE_DEFAULT;
          res_nxt.rect_height = head_op.rect_has_size ? {h[8], h[7]} : SIZE_DEFAULT;
          res_nxt.fore_color = rect_color_nxt;
        end
        KIND_CHAR: begin
          res_nxt.code_byte = h[1];
          res_nxt.pos_x = {h[3], h[2]};
          res_nxt.pos_y = {h[5], h[4]};
          res_nxt.fore_color = {h[6], h[7], h[8]};
          res_nxt.back_color = {h[9], h[10], h[11]};
        end
        KIND_WAVE_END: begin
          res_nxt.fore_color = {h[1], h[2], h[3]};
          res_nxt.sample_count = head_op.wave_total;
        end
        KIND_FONT: begin
          res_nxt.code_byte = h[5];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r <= 1'b0;
      rect_color_r <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        phase_r <= !last_of_op;
        rect_color_r <= rect_color_nxt;
      end else if (res_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res = res_r;

endmodule

// ----- hw/rtl/display_command_frame_decoder.sv -----
// Top level of the display command frame decoder.
`timescale 1ns / 1ps

// The block takes frame bytes on a queue-like input: drive in_frame_byte and
// in_frame_end with in_push high; a transfer happens on a clock edge where
// in_full is low. Results appear on the out_ ports while out_empty is low,
// oldest first, and each one is removed by a transfer with out_pop high.
// A byte can be taken every cycle while in_full is low. A byte's operation
// is written into the queue, then loaded into the output register, where
// its first result shows. A waveform byte that also ends its frame gives
// two results, one after the other, so the output side sets the rate at
// one result per cycle while out_pop stays high. When the receiver stalls,
// results wait in a four-entry queue and an output register, and in_full
// rises once the queue fills. Bytes that cause no result pass without
// using queue space. Reset clears the byte count, the kept rectangle color,
// the queue and the output register; no clearing pass is needed.
module display_command_frame_decoder #(
  parameter int MAX_SAMPLES = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_end,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_result_kind,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y,
  output logic [15:0] out_rect_width,
  output logic [15:0] out_rect_height,
  output logic [23:0] out_fore_color,
  output logic [23:0] out_back_color,
  output logic [7:0]  out_code_byte,
  output logic [8:0]  out_sample_count,
  output logic        out_run_last
);
  import dcfd_pkg::*;

  logic accept;
  logic op_push;
  op_t  op;
  logic q_full;
  logic head_valid;
  op_t  head_op;
  logic head_pop;
  logic res_valid;
  res_t res;

  assign in_full = q_full;
  assign accept = in_push && !q_full;

  dcfd_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .frame_byte (in_frame_byte),
    .frame_end  (in_frame_end),
    .op_push    (op_push),
    .op         (op)
  );

  dcfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (op_push),
    .push_op    (op),
    .full       (q_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  dcfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_op    (head_op),
    .head_pop   (head_pop),
    .res_valid  (res_valid),
    .res        (res),
    .res_pop    (out_pop)
  );

  assign out_empty = !res_valid;
  assign out_result_kind = res.result_kind;
  assign out_pos_x = res.pos_x;
  assign out_pos_y = res.pos_y;
  assign out_rect_width = res.rect_width;
  assign out_rect_height = res.rect_height;
  assign out_fore_color = res.fore_color;
  assign out_back_color = res.back_color;
  assign out_code_byte = res.code_byte;
  assign out_sample_count = res.sample_count;
  assign out_run_last = res.run_last;

endmodule

// ----- bench/dcfd_result_checker.sv -----
// Checker that predicts and compares the display command frame decoder's results.
`timescale 1ns / 1ps

module dcfd_result_checker #(
  parameter int MAX_SAMPLES = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_end,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [2:0]  out_result_kind,
  input  logic [15:0] out_pos_x,
  input  logic [15:0] out_pos_y,
  input  logic [15:0] out_rect_width,
  input  logic [15:0] out_rect_height,
  input  logic [23:0] out_fore_color,
  input  logic [23:0] out_back_color,
  input  logic [7:0]  out_code_byte,
  input  logic [8:0]  out_sample_count,
  input  logic        out_run_last,
  output int          fail_count,
  output int          awaited_count
);
  import dcfd_pkg::*;

  logic [7:0]  frame_head [HDR_DEPTH];
  logic [8:0]  frame_pos;
  logic [23:0] kept_rect_color;
  res_t        awaited_results [$];

  function automatic logic [15:0] head_word(input int at);
    return {frame_head[at + 1], frame_head[at]};
  endfunction

  function automatic logic [23:0] head_color(input int at);
    return {frame_head[at], frame_head[at + 1], frame_head[at + 2]};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("mismatch in %s: got %0h, expected %0h at %0t ns", what, got, want, $time);
    end
  endtask

  task automatic decode_byte(input logic [7:0] value, input logic last);
    int          idx;
    int          size;
    logic [7:0]  cmd;
    logic [15:0] w;
    logic [15:0] h;
    logic        ok;
    res_t        r;
    idx = int'(frame_pos);
    if (idx < HDR_DEPTH) begin
      frame_head[idx] = value;
    end
    cmd = frame_head[0];
    if (cmd == CMD_WAVE && idx >= 4 && idx - 4 < MAX_SAMPLES) begin
      r = '0;
      r.result_kind = KIND_SAMPLE;
      r.fore_color = head_color(1);
      r.code_byte = value;
      r.sample_count = 9'(idx - 4);
      r.run_last = !last;
      awaited_results.push_back(r);
    end
    if (!last) begin
      if (frame_pos != COUNT_MAX) begin
        frame_pos++;
      end
      return;
    end
    size = idx + 1;
    r = '0;
    r.result_kind = KIND_IGNORED;
    r.run_last = 1'b1;
    if (cmd == CMD_RECT) begin
      w = SIZE_DEFAULT;
      h = SIZE_DEFAULT;
      ok = 1'b1;
      case (size)
        5: ;
        8: kept_rect_color = head_color(5);
        9: begin
          w = head_word(5);
          h = head_word(7);
        end
        12: begin
          w = head_word(5);
          h = head_word(7);
          kept_rect_color = head_color(9);
        end
        default: ok = 1'b0;
      endcase
      if (ok) begin
        r.result_kind = KIND_RECT;
        r.pos_x = head_word(1);
        r.pos_y = head_word(3);
        r.rect_width = w;
        r.rect_height = h;
        r.fore_color = kept_rect_color;
      end else begin
        r.result_kind = KIND_REJECT;
      end
    end else if (cmd == CMD_CHAR) begin
      if (size == 12) begin
        r.result_kind = KIND_CHAR;
        r.code_byte = frame_head[1];
        r.pos_x = head_word(2);
        r.pos_y = head_word(4);
        r.fore_color = head_color(6);
        r.back_color = head_color(9);
      end else begin
        r.result_kind = KIND_REJECT;
      end
    end else if (cmd == CMD_WAVE) begin
      if (size >= 4 && size <= 4 + MAX_SAMPLES) begin
        r.result_kind = KIND_WAVE_END;
        r.fore_color = head_color(1);
        r.sample_count = 9'(size - 4);
      end else begin
        r.result_kind = KIND_REJECT;
      end
    end else if (cmd == CMD_FONT) begin
      if (size == 6) begin
        r.result_kind = KIND_FONT;
        r.code_byte = frame_head[5];
      end
    end
    awaited_results.push_back(r);
    frame_pos = '0;
  endtask

  task automatic check_result();
    res_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("result with none expected", 32'(out_result_kind), '0);
      return;
    end
    want = awaited_results.pop_front();
    if (out_result_kind !== want.result_kind) begin
      report_mismatch("result_kind", 32'(out_result_kind), 32'(want.result_kind));
    end
    if (out_pos_x !== want.pos_x) begin
      report_mismatch("pos_x", 32'(out_pos_x), 32'(want.pos_x));
    end
    if (out_pos_y !== want.pos_y) begin
      report_mismatch("pos_y", 32'(out_pos_y), 32'(want.pos_y));
    end
    if (out_rect_width !== want.rect_width) begin
      report_mismatch("rect_width", 32'(out_rect_width), 32'(want.rect_width));
    end
    if (out_rect_height !== want.rect_height) begin
      report_mismatch("rect_height", 32'(out_rect_height), 32'(want.rect_height));
    end
    if (out_fore_color !== want.fore_color) begin
      report_mismatch("fore_color", 32'(out_fore_color), 32'(want.fore_color));
    end
    if (out_back_color !== want.back_color) begin
      report_mismatch("back_color", 32'(out_back_color), 32'(want.back_color));
    end
    if (out_code_byte !== want.code_byte) begin
      report_mismatch("code_byte", 32'(out_code_byte), 32'(want.code_byte));
    end
    if (out_sample_count !== want.sample_count) begin
      report_mismatch("sample_count", 32'(out_sample_count), 32'(want.sample_count));
    end
    if (out_run_last !== want.run_last) begin
      report_mismatch("run_last", 32'(out_run_last), 32'(want.run_last));
    end
  endtask

  // A result leaving at this edge always belongs to an earlier byte, so it is
  // checked before the byte taken at the same edge is decoded.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (frame_head[i]) frame_head[i] = '0;
      frame_pos = '0;
      kept_rect_color = '0;
      awaited_results.delete();
      fail_count = 0;
    end else begin
      if (out_empty === 1'b0 && out_pop === 1'b1) begin
        check_result();
      end
      if (in_push === 1'b1 && in_full === 1'b0) begin
        decode_byte(in_frame_byte, in_frame_end);
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

// ----- bench/tb_display_command_frame_decoder.sv -----
// Testbench top for the display command frame decoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_display_command_frame_decoder;
  import dcfd_pkg::*;

  localparam int MAX_SAMPLES = 480;
  localparam int HOLD_CYCLES = 60;
  localparam int BYTE_TARGET = 1150;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_frame_byte;
  logic        in_frame_end;
  logic        out_empty;
  logic        out_pop;
  logic [2:0]  out_result_kind;
  logic [15:0] out_pos_x;
  logic [15:0] out_pos_y;
  logic [15:0] out_rect_width;
  logic [15:0] out_rect_height;
  logic [23:0] out_fore_color;
  logic [23:0] out_back_color;
  logic [7:0]  out_code_byte;
  logic [8:0]  out_sample_count;
  logic        out_run_last;

  int fail_count;
  int awaited_count;
  int idle_pct;
  int stall_pct;
  int byte_total;
  bit hold_req;

  display_command_frame_decoder #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_frame_byte(in_frame_byte),
    .in_frame_end(in_frame_end),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_result_kind(out_result_kind),
    .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y),
    .out_rect_width(out_rect_width),
    .out_rect_height(out_rect_height),
    .out_fore_color(out_fore_color),
    .out_back_color(out_back_color),
    .out_code_byte(out_code_byte),
    .out_sample_count(out_sample_count),
    .out_run_last(out_run_last)
  );

  dcfd_result_checker #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_frame_byte(in_frame_byte),
    .in_frame_end(in_frame_end),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_result_kind(out_result_kind),
    .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y),
    .out_rect_width(out_rect_width),
    .out_rect_height(out_rect_height),
    .out_fore_color(out_fore_color),
    .out_back_color(out_back_color),
    .out_code_byte(out_code_byte),
    .out_sample_count(out_sample_count),
    .out_run_last(out_run_last),
    .fail_count(fail_count),
    .awaited_count(awaited_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with in_push still high, so the next byte can follow without a gap.
  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_frame_byte <= value;
    in_frame_end <= last;
    do @(posedge clk); while (in_full);
    byte_total++;
    @(negedge clk);
  endtask

  // A negative fill gives random content after the command byte.
  task automatic send_frame(input logic [7:0] first, input int len, input int fill);
    logic [7:0] value;
    send_byte(first, len == 1);
    for (int i = 1; i < len; i++) begin
      value = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      send_byte(value, i == len - 1);
    end
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    do @(negedge clk); while (awaited_count != 0);
  endtask

  initial begin
    int         frame_no;
    int         len;
    int         pick;
    logic [7:0] first;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_frame_byte = '0;
    in_frame_end = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    byte_total = 0;
    hold_req = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_frame(CMD_RECT, 5, 0);
    send_frame(CMD_RECT, 8, 255);
    send_frame(CMD_WAVE, 5, -1);
    send_frame(CMD_WAVE, 3, -1);
    send_frame(CMD_FONT, 6, -1);
    send_frame(8'h00, 1, -1);
    send_frame(CMD_RECT, 1, -1);

    // The receiver holds off while a waveform keeps the sender busy, so the
    // result queue fills and the input stalls.
    hold_req = 1'b1;
    send_frame(CMD_WAVE, 24, -1);
    drain_results();

    frame_no = 0;
    while (byte_total < BYTE_TARGET) begin
      if (frame_no % 6 == 0) begin
        drain_results();
        case ((frame_no / 6) % 4)
          0: begin
            idle_pct = 0;
            stall_pct = 0;
          end
          1: begin
            idle_pct = 69;
            stall_pct = 0;
          end
          2: begin
            idle_pct = 0;
            stall_pct = 69;
          end
          default: begin
            idle_pct = 22;
            stall_pct = 22;
          end
        endcase
      end
      if (frame_no == 13) begin
        send_frame(CMD_WAVE, 4 + MAX_SAMPLES, -1);
      end else if (frame_no == 20) begin
        send_frame(CMD_WAVE, 514, -1);
      end else begin
        pick = $urandom_range(99);
        if (pick < 28) begin
          first = CMD_RECT;
          case ($urandom_range(4))
            0: len = 5;
            1: len = 8;
            2: len = 9;
            3: len = 12;
            default: len = $urandom_range(1, 14);
          endcase
        end else if (pick < 48) begin
          first = CMD_CHAR;
          len = ($urandom_range(3) == 0) ? $urandom_range(1, 14) : 12;
        end else if (pick < 68) begin
          first = CMD_WAVE;
          len = ($urandom_range(5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 20);
        end else if (pick < 83) begin
          first = CMD_FONT;
          len = ($urandom_range(3) == 0) ? $urandom_range(1, 9) : 6;
        end else if (pick < 93) begin
          first = 8'($urandom_range(8'hFB));
          len = $urandom_range(1, 10);
        end else begin
          first = 8'($urandom_range(255));
          len = $urandom_range(1, 16);
        end
        send_frame(first, len, -1);
      end
      frame_no++;
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
